// ===== src/i2c_master_byte_sequencer_core_assert.svh =====
// Assertion macros for the I2C master byte sequencer core.
// Used by the front and engine modules; needs clk_i and rst_ni in scope.
`ifndef I2C_MASTER_BYTE_SEQUENCER_CORE_ASSERT_SVH
`define I2C_MASTER_BYTE_SEQUENCER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Clocked check, disabled while reset is asserted
`define I2CMS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds during reset
`define I2CMS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`else

`define I2CMS_ASSERT(label, prop, msg)
`define I2CMS_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

// ===== src/i2cms_pkg.sv =====
// Package for the I2C master byte sequencer: payload structs, command codes
// and bus phase constants. No dependencies.
package i2cms_pkg;

  // Command codes carried in the action field
  typedef enum logic [2:0] {
    OP_IDLE      = 3'd0,
    OP_START     = 3'd1,
    OP_STOP      = 3'd2,
    OP_WRITE     = 3'd3,
    OP_READ_ACK  = 3'd4,
    OP_READ_NACK = 3'd5
  } op_e;

  // Input transaction
  typedef struct packed {
    logic [2:0] action;
    logic [7:0] data_byte;
    logic       sda_in;
  } in_t;

  // Result transaction
  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic       no_ack;
    logic [7:0] read_byte;
  } out_t;

  // Classified command between front and engine
  typedef struct packed {
    op_e        op;
    logic [7:0] data_byte;
    logic       sda_in;
  } cmd_t;

  localparam logic [7:0] PHASE_TICKS_RESET = 8'd25;

  // Last phase index of each command
  localparam logic [4:0] START_LAST = 5'd2;
  localparam logic [4:0] STOP_LAST  = 5'd1;
  localparam logic [4:0] WRITE_LAST = 5'd26;
  localparam logic [4:0] READ_LAST  = 5'd18;

  // Landmark phases of write and read
  localparam logic [4:0] WR_ACK_PHASE    = 5'd24;
  localparam logic [4:0] WR_SAMPLE_PHASE = 5'd25;
  localparam logic [4:0] RD_ANSWER_PHASE = 5'd16;
  localparam logic [4:0] RD_ANS_HI_PHASE = 5'd17;
  localparam logic [2:0] LAST_BIT        = 3'd7;
  localparam logic [1:0] SUB_LAST        = 2'd2;

endpackage

// ===== src/i2c_master_byte_sequencer_core.sv =====
// Top level of the I2C master byte sequencer core.
// Instantiates the command front (decode + queue) and the bus engine.
//
// Usage: each input transaction on in_valid_i/in_ready_o/in_data_i is one
// tick of the bus timing. Its action field may carry a command (start, stop,
// write byte, read with ack, read with nack); it is taken only when the
// engine is idle, otherwise ignored. data_byte is latched at launch, sda_in
// is the sampled SDA level for this tick. Every input transaction yields
// exactly one result transaction on out_valid_o/out_ready_i/out_data_o with
// SCL/SDA drive, busy, done, no-ack and the last read byte.
// phase_ticks is written through cfg_we_i/cfg_wdata_i (reset 25, 0 acts as 1)
// and should only change while no transaction is outstanding.
// Throughput: one transaction per cycle while out_ready_i is high; a stalled
// receiver holds the flow. Each input passes through the command queue and
// then the result register before its result shows on out_valid_o.
// Reset clears the queue and returns the engine to idle with both lines
// released. When the receiver stalls, the result register holds and the
// queue absorbs up to two transactions before in_ready_o drops.
module i2c_master_byte_sequencer_core
  import i2cms_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_t        in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_t       out_data_o,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i
);

  logic cmd_valid, cmd_ready;
  cmd_t cmd;

  i2cms_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  i2cms_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== src/i2cms_front.sv =====
// Front part of the I2C master byte sequencer: decodes the action field and
// buffers classified commands in a two-entry queue. Depends on i2cms_pkg.
`include "i2c_master_byte_sequencer_core_assert.svh"

module i2cms_front
  import i2cms_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic cmd_valid_o,
  input  logic cmd_ready_i,
  output cmd_t cmd_o
);

  cmd_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;
  cmd_t       cmd_new;

  // Classify: undefined codes become no command
  always_comb begin
    cmd_new.data_byte = in_data_i.data_byte;
    cmd_new.sda_in    = in_data_i.sda_in;
    if (in_data_i.action inside {[OP_START:OP_READ_NACK]}) begin
      cmd_new.op = op_e'(in_data_i.action);
    end else begin
      cmd_new.op = OP_IDLE;
    end
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = mem_q[rd_ptr_q];

  // Fill count
  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  // Queue pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop)  rd_ptr_q <= !rd_ptr_q;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= cmd_new;
    end
  end

  `I2CMS_ASSERT_ALWAYS(a_cnt_range, cnt_q != 2'd3, "queue count out of range")
  `I2CMS_ASSERT(a_no_pop_empty, pop |-> cnt_q != 2'd0, "pop from empty queue")
  `I2CMS_ASSERT(a_cnt_grows, (push && !pop) |=> cnt_q == $past(cnt_q) + 2'd1,
                "queue count did not grow on push")

endmodule

// ===== src/i2cms_engine.sv =====
// Back part of the I2C master byte sequencer: bus phase sequencer, phase
// timer, shift register and the result register. Depends on i2cms_pkg.
`include "i2c_master_byte_sequencer_core_assert.svh"

module i2cms_engine
  import i2cms_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       cmd_valid_i,
  output logic       cmd_ready_o,
  input  cmd_t       cmd_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_t       out_data_o
);

  op_e        op_q, op_d;
  logic [4:0] phase_q, phase_d, phase_n;
  logic [1:0] sub_q, sub_d, sub_n;
  logic [2:0] bit_q, bit_d, bit_n;
  logic [7:0] tick_q, tick_d;
  logic [7:0] shift_q, shift_d;
  logic       scl_q, scl_d, sda_q, sda_d;
  logic       ack_q, ack_d;
  logic [7:0] hold_q, hold_d;
  logic [7:0] pt_q;
  logic       out_valid_q;
  out_t       out_q;

  logic       fire, done_w, is_read;
  logic [7:0] len;
  logic [8:0] tick_inc;
  logic [4:0] last_phase;

  assign cmd_ready_o = !out_valid_q || out_ready_i;
  assign fire        = cmd_valid_i && cmd_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign len      = (pt_q == 8'd0) ? 8'd1 : pt_q;
  assign tick_inc = {1'b0, tick_q} + 9'd1;
  assign is_read  = (op_q == OP_READ_ACK) || (op_q == OP_READ_NACK);
  assign phase_n  = phase_q + 5'd1;
  assign sub_n    = (sub_q == SUB_LAST) ? 2'd0 : sub_q + 2'd1;
  assign bit_n    = (sub_q == SUB_LAST) ? bit_q + 3'd1 : bit_q;

  // Last phase of the running command
  always_comb begin
    case (op_q)
      OP_START: last_phase = START_LAST;
      OP_STOP:  last_phase = STOP_LAST;
      OP_WRITE: last_phase = WRITE_LAST;
      default:  last_phase = READ_LAST;
    endcase
  end

  // One tick of the sequencer
  always_comb begin
    op_d    = op_q;
    phase_d = phase_q;
    sub_d   = sub_q;
    bit_d   = bit_q;
    tick_d  = tick_q;
    shift_d = shift_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    ack_d   = ack_q;
    hold_d  = hold_q;
    done_w  = 1'b0;
    if (fire) begin
      if (op_q == OP_IDLE) begin
        // Launch a command and enter its first phase
        if (cmd_i.op != OP_IDLE) begin
          op_d    = cmd_i.op;
          phase_d = 5'd0;
          sub_d   = 2'd0;
          bit_d   = 3'd0;
          tick_d  = 8'd0;
          shift_d = (cmd_i.op == OP_WRITE) ? cmd_i.data_byte : 8'h00;
          case (cmd_i.op)
            OP_START: begin
              sda_d = 1'b1;
              scl_d = 1'b1;
            end
            OP_STOP: begin
              sda_d = 1'b0;
              scl_d = 1'b1;
            end
            OP_WRITE: begin
              sda_d = cmd_i.data_byte[7];
            end
            default: begin
              scl_d = 1'b1;
            end
          endcase
        end
      end else if (tick_inc >= {1'b0, len}) begin
        tick_d = 8'd0;
        // Phase close: ACK sample or read bit sample
        if (op_q == OP_WRITE && phase_q == WR_SAMPLE_PHASE) begin
          ack_d = cmd_i.sda_in;
        end else if (is_read && phase_q < RD_ANSWER_PHASE && !phase_q[0]) begin
          shift_d = {shift_q[6:0], cmd_i.sda_in};
        end
        if (phase_q == last_phase) begin
          // Command complete
          done_w  = 1'b1;
          if (is_read) hold_d = shift_d;
          if (op_q == OP_READ_ACK) sda_d = 1'b1;
          op_d    = OP_IDLE;
          phase_d = 5'd0;
        end else begin
          // Enter the next phase
          phase_d = phase_n;
          sub_d   = sub_n;
          bit_d   = bit_n;
          case (op_q)
            OP_START: begin
              if (phase_n == 5'd1) sda_d = 1'b0;
              else scl_d = 1'b0;
            end
            OP_STOP: begin
              sda_d = 1'b1;
            end
            OP_WRITE: begin
              if (phase_n < WR_ACK_PHASE) begin
                case (sub_n)
                  2'd0: sda_d = shift_q[7];
                  2'd1: scl_d = 1'b1;
                  default: begin
                    scl_d   = 1'b0;
                    if (bit_n == LAST_BIT) sda_d = 1'b1;
                    shift_d = {shift_q[6:0], 1'b0};
                  end
                endcase
              end else if (phase_n == WR_ACK_PHASE) begin
                sda_d = 1'b1;
              end else if (phase_n == WR_SAMPLE_PHASE) begin
                scl_d = 1'b1;
              end else begin
                scl_d = 1'b0;
              end
            end
            default: begin
              if (phase_n < RD_ANSWER_PHASE) begin
                scl_d = !phase_n[0];
              end else if (phase_n == RD_ANSWER_PHASE) begin
                sda_d = (op_q == OP_READ_NACK);
              end else if (phase_n == RD_ANS_HI_PHASE) begin
                scl_d = 1'b1;
              end else begin
                scl_d = 1'b0;
              end
            end
          endcase
        end
      end else begin
        tick_d = tick_inc[7:0];
      end
    end
  end

  // Sequencer state, phase length register and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q        <= OP_IDLE;
      phase_q     <= 5'd0;
      sub_q       <= 2'd0;
      bit_q       <= 3'd0;
      tick_q      <= 8'd0;
      shift_q     <= 8'd0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      ack_q       <= 1'b0;
      hold_q      <= 8'd0;
      pt_q        <= PHASE_TICKS_RESET;
      out_valid_q <= 1'b0;
    end else begin
      op_q    <= op_d;
      phase_q <= phase_d;
      sub_q   <= sub_d;
      bit_q   <= bit_d;
      tick_q  <= tick_d;
      shift_q <= shift_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
      ack_q   <= ack_d;
      hold_q  <= hold_d;
      if (cfg_we_i) pt_q <= cfg_wdata_i;
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q.scl_out   <= scl_d;
      out_q.sda_out   <= sda_d;
      out_q.busy_res  <= (op_d != OP_IDLE);
      out_q.done_res  <= done_w;
      out_q.no_ack    <= ack_d;
      out_q.read_byte <= hold_d;
    end
  end

  `I2CMS_ASSERT(a_done_not_busy, (out_valid_q && out_q.done_res) |-> !out_q.busy_res,
                "done reported while still busy")
  `I2CMS_ASSERT(a_wr_counters, (op_q == OP_WRITE && phase_q < WR_ACK_PHASE) |->
                phase_q == 5'(bit_q) * 5'd3 + 5'(sub_q), "write bit counters out of step")
  `I2CMS_ASSERT(a_phase_bound, (op_q != OP_IDLE) |-> phase_q <= last_phase,
                "phase index past end of command")
  `I2CMS_ASSERT(a_done_from_busy, (fire && done_w) |=> op_q == OP_IDLE,
                "engine not idle after completion")

endmodule

// ===== dv/tb.sv =====
// Testbench for i2c_master_byte_sequencer_core: a tick-level predictor of the bus engine
// in a scoreboard class, valid/ready drivers with random idling, phase_ticks reconfiguration.
// Depends on i2cms_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb;
  import i2cms_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;

  // Bus engine predictor plus the queue of expected line levels
  class bus_tick_board;
    logic [7:0] phase_ticks;
    op_e        cur_op;
    logic [4:0] phase_idx;
    logic [7:0] tick_cnt;
    logic [7:0] shreg;
    logic       scl;
    logic       sda;
    logic       ack;
    logic [7:0] read_hold;
    out_t       expected_levels[$];
    int unsigned errors;
    int unsigned seen;

    function new();
      phase_ticks = PHASE_TICKS_RESET;
      cur_op      = OP_IDLE;
      phase_idx   = '0;
      tick_cnt    = '0;
      shreg       = '0;
      scl         = 1'b1;
      sda         = 1'b1;
      ack         = 1'b0;
      read_hold   = '0;
      errors      = 0;
      seen        = 0;
    endfunction

    // Zero acts as one tick per phase
    function int unsigned eff_len();
      return (phase_ticks == 8'd0) ? 1 : int'(phase_ticks);
    endfunction

    function int unsigned phase_total(op_e op);
      case (op)
        OP_START: return int'(START_LAST) + 1;
        OP_STOP:  return int'(STOP_LAST) + 1;
        OP_WRITE: return int'(WRITE_LAST) + 1;
        default:  return int'(READ_LAST) + 1;
      endcase
    endfunction

    // Line levels set on entering a phase
    function void enter(op_e op, logic [4:0] p);
      case (op)
        OP_START: begin
          if (p == 5'd0) begin
            sda = 1'b1;
            scl = 1'b1;
          end else if (p == 5'd1) begin
            sda = 1'b0;
          end else begin
            scl = 1'b0;
          end
        end
        OP_STOP: begin
          if (p == 5'd0) begin
            sda = 1'b0;
            scl = 1'b1;
          end else begin
            sda = 1'b1;
          end
        end
        OP_WRITE: begin
          if (p < WR_ACK_PHASE) begin
            if (p % 3 == 0) begin
              sda = shreg[7];
            end else if (p % 3 == 1) begin
              scl = 1'b1;
            end else begin
              scl = 1'b0;
              if (p / 3 == LAST_BIT) sda = 1'b1;
              shreg = {shreg[6:0], 1'b0};
            end
          end else if (p == WR_ACK_PHASE) begin
            sda = 1'b1;
          end else if (p == WR_SAMPLE_PHASE) begin
            scl = 1'b1;
          end else begin
            scl = 1'b0;
          end
        end
        default: begin
          if (p < RD_ANSWER_PHASE) begin
            scl = (p % 2 == 0);
          end else if (p == RD_ANSWER_PHASE) begin
            sda = (op == OP_READ_ACK) ? 1'b0 : 1'b1;
          end else if (p == RD_ANS_HI_PHASE) begin
            scl = 1'b1;
          end else begin
            scl = 1'b0;
          end
        end
      endcase
    endfunction

    // SDA sampling at the close of an SCL-high phase
    function void close(op_e op, logic [4:0] p, logic s);
      if (op == OP_WRITE && p == WR_SAMPLE_PHASE) begin
        ack = s;
      end else if ((op == OP_READ_ACK || op == OP_READ_NACK) &&
                   p < RD_ANSWER_PHASE && p % 2 == 0) begin
        shreg = {shreg[6:0], s};
      end
    endfunction

    // One accepted input transaction: advance one tick, queue the levels
    function void take_tick(in_t t);
      int unsigned nxt;
      logic        fin;
      out_t        e;
      fin = 1'b0;
      if (cur_op == OP_IDLE) begin
        if (t.action >= OP_START && t.action <= OP_READ_NACK) begin
          cur_op    = op_e'(t.action);
          phase_idx = '0;
          tick_cnt  = '0;
          if (cur_op == OP_WRITE) shreg = t.data_byte;
          else if (cur_op == OP_READ_ACK || cur_op == OP_READ_NACK) shreg = '0;
          enter(cur_op, phase_idx);
        end
      end else begin
        nxt = int'(tick_cnt) + 1;
        if (nxt >= eff_len()) begin
          tick_cnt = '0;
          close(cur_op, phase_idx, t.sda_in);
          if (int'(phase_idx) + 1 >= phase_total(cur_op)) begin
            if (cur_op == OP_READ_ACK) sda = 1'b1;
            if (cur_op == OP_READ_ACK || cur_op == OP_READ_NACK) read_hold = shreg;
            cur_op    = OP_IDLE;
            phase_idx = '0;
            fin       = 1'b1;
          end else begin
            phase_idx = phase_idx + 5'd1;
            enter(cur_op, phase_idx);
          end
        end else begin
          tick_cnt = nxt[7:0];
        end
      end
      e.scl_out   = scl;
      e.sda_out   = sda;
      e.busy_res  = (cur_op != OP_IDLE);
      e.done_res  = fin;
      e.no_ack    = ack;
      e.read_byte = read_hold;
      expected_levels.push_back(e);
    endfunction

    // One accepted result transaction against the oldest expectation
    function void match_levels(out_t got);
      out_t e;
      seen++;
      if (expected_levels.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result %0d arrived with nothing expected", seen);
        return;
      end
      e = expected_levels.pop_front();
      if (got !== e) begin
        errors++;
        if (errors <= 10) begin
          $display("result %0d mismatch: exp scl=%b sda=%b busy=%b done=%b nack=%b rd=%h",
                   seen, e.scl_out, e.sda_out, e.busy_res, e.done_res, e.no_ack,
                   e.read_byte);
          $display("result %0d mismatch: got scl=%b sda=%b busy=%b done=%b nack=%b rd=%h",
                   seen, got.scl_out, got.sda_out, got.busy_res, got.done_res,
                   got.no_ack, got.read_byte);
        end
      end
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  in_t        in_data_i;
  logic       out_valid_o;
  logic       out_ready_i;
  out_t       out_data_o;
  logic       cfg_we_i;
  logic [7:0] cfg_wdata_i;

  bit          gaps_on;
  int unsigned cycles;

  bus_tick_board board = new();

  i2c_master_byte_sequencer_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // 10 ns clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog
  initial cycles = 0;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Monitor: note accepted inputs, check accepted results
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) board.take_tick(in_data_i);
      if (out_valid_o && out_ready_i) board.match_levels(out_data_o);
    end
  end

  // Receiver with random stall bursts
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && gaps_on && $urandom_range(0, 7) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  function automatic logic sda_pick(int mode);
    return (mode < 0) ? 1'($urandom) : mode[0];
  endfunction

  // One input transaction, with an optional idle burst ahead of it
  task automatic send_tick(in_t t);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= t;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Filler ticks; noisy ones carry commands that a busy engine must ignore
  task automatic send_fill(int unsigned n, int sda_mode, bit noisy);
    in_t t;
    repeat (n) begin
      t.action    = noisy ? 3'($urandom_range(1, 7)) : 3'(OP_IDLE);
      t.data_byte = 8'($urandom);
      t.sda_in    = sda_pick(sda_mode);
      send_tick(t);
    end
  endtask

  // A command from idle, followed by ticks up to and including its done tick
  task automatic run_cmd(op_e op, logic [7:0] data, int sda_mode, bit noisy);
    in_t t;
    t.action    = op;
    t.data_byte = data;
    t.sda_in    = sda_pick(sda_mode);
    send_tick(t);
    send_fill(board.phase_total(op) * board.eff_len(), sda_mode, noisy);
  endtask

  task automatic send_undef(logic [2:0] code);
    in_t t;
    t.action    = code;
    t.data_byte = 8'($urandom);
    t.sda_in    = 1'($urandom);
    send_tick(t);
  endtask

  // Register write once every outstanding result has come back
  task automatic set_phase_ticks(logic [7:0] v);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.expected_levels.size() != 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.phase_ticks = v;
  endtask

  // Random ticks: mostly idle ticks with commands mixed in, a few undefined codes
  task automatic run_random(int unsigned n);
    in_t         t;
    int unsigned r;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 15) t.action = 3'($urandom_range(1, 5));
      else if (r < 18) t.action = 3'($urandom_range(6, 7));
      else t.action = OP_IDLE;
      t.data_byte = 8'($urandom);
      t.sda_in    = 1'($urandom);
      send_tick(t);
    end
  endtask

  logic [7:0] rand_settings[7];

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    gaps_on     = 1'b1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset phase length: stop on an idle bus
    run_cmd(OP_STOP, 8'h00, -1, 1'b0);

    // Longest phases: a stop held for some ticks with commands offered,
    // then cut to one tick per phase
    set_phase_ticks(8'd255);
    begin
      in_t t;
      t.action    = OP_STOP;
      t.data_byte = 8'($urandom);
      t.sda_in    = 1'($urandom);
      send_tick(t);
    end
    send_fill(10, -1, 1'b1);
    set_phase_ticks(8'd1);
    send_fill(4, -1, 1'b0);

    // Zero length acts as one: byte and ack extremes
    set_phase_ticks(8'd0);
    run_cmd(OP_WRITE, 8'h00, 0, 1'b0);
    run_cmd(OP_WRITE, 8'hFF, 1, 1'b0);
    run_cmd(OP_READ_ACK, 8'h00, 1, 1'b0);
    run_cmd(OP_READ_NACK, 8'hFF, 0, 1'b0);
    run_cmd(OP_STOP, 8'h00, -1, 1'b0);
    run_cmd(OP_START, 8'h00, -1, 1'b0);

    // Undefined codes, and commands while busy up to the done tick
    set_phase_ticks(8'd1);
    send_undef(3'd6);
    send_undef(3'd7);
    run_cmd(OP_WRITE, 8'($urandom), -1, 1'b1);
    run_cmd(OP_READ_NACK, 8'h00, -1, 1'b1);

    set_phase_ticks(8'd2);
    run_cmd(OP_START, 8'h00, -1, 1'b1);
    run_cmd(OP_READ_ACK, 8'h00, -1, 1'b1);

    // Length cut below the running count mid-command
    set_phase_ticks(8'd4);
    run_cmd(OP_STOP, 8'h00, -1, 1'b0);
    send_fill(0, -1, 1'b0);
    begin
      in_t t;
      t.action    = OP_WRITE;
      t.data_byte = 8'($urandom);
      t.sda_in    = 1'($urandom);
      send_tick(t);
    end
    send_fill(3, -1, 1'b0);
    set_phase_ticks(8'd2);
    send_fill(60, -1, 1'b0);

    // Random part across several lengths; the last stretch runs without idling
    rand_settings = '{8'd1, 8'd2, 8'd3, 8'd0, 8'($urandom_range(1, 4)), 8'd2, 8'd1};
    foreach (rand_settings[i]) begin
      set_phase_ticks(rand_settings[i]);
      if (i == 6) gaps_on = 1'b0;
      run_random(15);
    end

    // Drain and finish
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.expected_levels.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (board.errors == 0 && board.expected_levels.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/i2cms_pkg.sv
src/i2cms_front.sv
src/i2cms_engine.sv
src/i2c_master_byte_sequencer_core.sv
dv/tb.sv
